@@ rtl/llcc_pkg.sv @@
// Shared widths, register map and handoff types for the laser line column centroid block.
package llcc_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned ROW_W    = 10;
  localparam int unsigned COL_W    = 11;
  localparam int unsigned WSUM_W   = 18;
  localparam int unsigned MSUM_W   = 28;
  localparam int unsigned PROD_W   = ROW_W + PIX_W;
  localparam int unsigned CENT_W   = 18;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned DIV_STEPS = CENT_W;
  localparam int unsigned CNT_W    = $clog2(DIV_STEPS);

  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [0:0]       REG_THRESHOLD  = 1'b0;
  localparam logic [PIX_W-1:0] THRESHOLD_RST  = 8'd50;

  localparam logic [WSUM_W-1:0] WSUM_MAX = {WSUM_W{1'b1}};
  localparam logic [MSUM_W-1:0] MSUM_MAX = {MSUM_W{1'b1}};
  localparam logic [CENT_W-1:0] CENT_MAX = {CENT_W{1'b1}};

  typedef struct packed {
    logic              valid;
    logic [COL_W-1:0]  column;
    logic [PIX_W-1:0]  peak;
    logic [WSUM_W-1:0] weight;
    logic [MSUM_W-1:0] moment;
  } llcc_job_t;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [CENT_W-1:0] centroid;
    logic [PIX_W-1:0]  peak;
  } llcc_res_t;

endpackage

@@ rtl/llcc_accum.sv @@
// Run tracking and best-run selection over the pixels of one column.
module llcc_accum
  import llcc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [PIX_W-1:0] thr_i,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic [ROW_W-1:0] row_i,
  input  logic [COL_W-1:0] col_i,
  input  logic             last_i,
  output llcc_job_t        job_o
);

  logic              in_run_q, in_run_d;
  logic [PIX_W-1:0]  run_peak_q, run_peak_d;
  logic [WSUM_W-1:0] run_w_q, run_w_d;
  logic [MSUM_W-1:0] run_m_q, run_m_d;
  logic              best_v_q, best_v_d;
  logic [PIX_W-1:0]  best_peak_q, best_peak_d;
  logic [WSUM_W-1:0] best_w_q, best_w_d;
  logic [MSUM_W-1:0] best_m_q, best_m_d;

  logic              bright;
  logic [PROD_W-1:0] prod;
  logic [WSUM_W:0]   w_sum;
  logic [MSUM_W:0]   m_sum;
  logic              run_live;
  logic              closing;
  logic              replace;

  assign bright = pixel_i > thr_i;
  assign prod   = PROD_W'(row_i) * PROD_W'(pixel_i);
  assign w_sum  = {1'b0, run_w_q} + (WSUM_W + 1)'(pixel_i);
  assign m_sum  = {1'b0, run_m_q} + (MSUM_W + 1)'(prod);

  always_comb begin
    run_peak_d = run_peak_q;
    run_w_d    = run_w_q;
    run_m_d    = run_m_q;
    if (bright) begin
      if (!in_run_q) begin
        run_peak_d = pixel_i;
        run_w_d    = WSUM_W'(pixel_i);
        run_m_d    = MSUM_W'(prod);
      end else begin
        run_peak_d = (pixel_i > run_peak_q) ? pixel_i : run_peak_q;
        run_w_d    = w_sum[WSUM_W] ? WSUM_MAX : w_sum[WSUM_W-1:0];
        run_m_d    = m_sum[MSUM_W] ? MSUM_MAX : m_sum[MSUM_W-1:0];
      end
    end
  end

  assign run_live = bright || in_run_q;
  assign closing  = run_live && (!bright || last_i);
  assign replace  = closing && (!best_v_q || (run_peak_d > best_peak_q));

  always_comb begin
    best_v_d    = best_v_q || replace;
    best_peak_d = replace ? run_peak_d : best_peak_q;
    best_w_d    = replace ? run_w_d    : best_w_q;
    best_m_d    = replace ? run_m_d    : best_m_q;
    in_run_d    = run_live && !closing;
    if (last_i) begin
      best_v_d = 1'b0;
      in_run_d = 1'b0;
    end
  end

  always_comb begin
    job_o.valid  = fire_i && last_i && (best_v_q || replace);
    job_o.column = col_i;
    job_o.peak   = replace ? run_peak_d : best_peak_q;
    job_o.weight = replace ? run_w_d    : best_w_q;
    job_o.moment = replace ? run_m_d    : best_m_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q <= 1'b0;
      best_v_q <= 1'b0;
    end else if (fire_i) begin
      in_run_q <= in_run_d;
      best_v_q <= best_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      run_peak_q  <= run_peak_d;
      run_w_q     <= run_w_d;
      run_m_q     <= run_m_d;
      best_peak_q <= best_peak_d;
      best_w_q    <= best_w_d;
      best_m_q    <= best_m_d;
    end
  end

endmodule

@@ rtl/llcc_div.sv @@
// Restoring divider, one quotient bit per cycle, for the Q.8 centroid.
module llcc_div
  import llcc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  llcc_job_t job_i,
  input  logic      take_i,
  output logic      busy_o,
  output logic      done_o,
  output llcc_res_t res_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam int unsigned HI_W = MSUM_W - (CENT_W - FRAC_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WSUM_W-1:0] rem_q, rem_d;
  logic [CENT_W-1:0] dvd_q, dvd_d;
  logic [CENT_W-1:0] quo_q, quo_d;
  logic [WSUM_W-1:0] dvs_q, dvs_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [PIX_W-1:0]  peak_q, peak_d;

  logic [WSUM_W:0]   rem_sh;
  logic [WSUM_W+1:0] diff;
  logic              ge;
  logic [HI_W-1:0]   m_hi;

  assign rem_sh = {rem_q, dvd_q[CENT_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign ge     = !diff[WSUM_W+1];
  assign m_hi   = job_i.moment[MSUM_W-1 -: HI_W];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    col_d   = col_q;
    peak_d  = peak_q;
    unique case (state_q)
      S_IDLE: begin
        if (job_i.valid) begin
          col_d  = job_i.column;
          peak_d = job_i.peak;
          dvs_d  = job_i.weight;
          rem_d  = WSUM_W'(m_hi);
          dvd_d  = {job_i.moment[CENT_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
          cnt_d  = '0;
          if (job_i.weight == '0) begin
            quo_d   = '0;
            state_d = S_DONE;
          end else if (WSUM_W'(m_hi) >= job_i.weight) begin
            quo_d   = CENT_MAX;
            state_d = S_DONE;
          end else begin
            quo_d   = '0;
            state_d = S_RUN;
          end
        end
      end
      S_RUN: begin
        rem_d = ge ? diff[WSUM_W-1:0] : rem_sh[WSUM_W-1:0];
        quo_d = {quo_q[CENT_W-2:0], ge};
        dvd_d = {dvd_q[CENT_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    col_q  <= col_d;
    peak_q <= peak_d;
  end

  assign busy_o         = state_q != S_IDLE;
  assign done_o         = state_q == S_DONE;
  assign res_o.column   = col_q;
  assign res_o.centroid = quo_q;
  assign res_o.peak     = peak_q;

  a_rem_below_dvs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN |-> rem_q < dvs_q)
    else $error("partial remainder not below divisor");

  a_run_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN && cnt_q == LAST_STEP |=> state_q == S_DONE)
    else $error("divider did not finish after last step");

  a_peak_bright : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> peak_q != '0)
    else $error("finished result carries zero peak");

endmodule

@@ rtl/laser_line_column_centroid.sv @@
// Laser line column centroid: top level with config register and output word register.
//
// Pixels enter on the input channel (in_valid_i / in_stall_o) column by column,
// top row to bottom, with row, column and last-row tags. One result word per
// column that holds a bright run leaves on the output channel
// (out_valid_o / out_stall_i): column, Q.8 centroid row and peak level.
// Ordinary pixels are taken one per cycle while the divider is idle. The bottom
// pixel of a column with a run starts the restoring divider, which yields one
// quotient bit per cycle: in_stall_o stays high while the divider is busy, from
// the division (skipped when the centroid saturates or the weight is zero)
// until the word moves from its done state into the output register.
// A waiting output word does not block new pixels; only a second finished
// division holds the divider, and with it the input, until the output
// register frees.
// threshold sits at byte address 0 of the APB port; the user must write it only
// while the block is idle, which the block does not enforce. Reset sets threshold
// to 50 and drops any open run, best run, division and output word.
module laser_line_column_centroid
  import llcc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [PIX_W-1:0]  pixel_i,
  input  logic [ROW_W-1:0]  row_index_i,
  input  logic [COL_W-1:0]  column_index_i,
  input  logic              last_in_column_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [COL_W-1:0]  column_out_o,
  output logic [CENT_W-1:0] centroid_q8_o,
  output logic [PIX_W-1:0]  peak_level_o
);

  logic [PIX_W-1:0] thr_q;
  logic             cfg_wr;
  logic             in_fire;
  llcc_job_t        job;
  llcc_res_t        res;
  logic             div_busy;
  logic             div_done;
  logic             out_load;
  logic             out_valid_q, out_valid_d;
  llcc_res_t        out_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1] == REG_THRESHOLD);
  assign prdata = (paddr[APB_AW-1] == REG_THRESHOLD) ? APB_DW'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RST;
    end else if (cfg_wr) begin
      thr_q <= pwdata[PIX_W-1:0];
    end
  end

  assign in_stall_o = div_busy;
  assign in_fire    = in_valid_i && !in_stall_o;

  llcc_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (in_fire),
    .thr_i   (thr_q),
    .pixel_i (pixel_i),
    .row_i   (row_index_i),
    .col_i   (column_index_i),
    .last_i  (last_in_column_i),
    .job_o   (job)
  );

  llcc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .job_i  (job),
    .take_i (out_load),
    .busy_o (div_busy),
    .done_o (div_done),
    .res_o  (res)
  );

  assign out_load    = div_done && (!out_valid_q || !out_stall_i);
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign column_out_o  = out_q.column;
  assign centroid_q8_o = out_q.centroid;
  assign peak_level_o  = out_q.peak;

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && div_done |=> div_done)
    else $error("finished word dropped while output held");

  a_no_pixel_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job.valid |=> !in_fire)
    else $error("pixel taken while column division pending");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("stalled output word changed");

endmodule
